// ===== rtl/core/aesp_pkg.sv =====
// Package for the escape-sequence stream parser.
// Holds action codes, character constants, the sequence state and result types.
// No dependencies.
package aesp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ParamW  = 16;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic [PaddrW-3:0] RegParseAnsi = '0;

  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChBel    = 8'h07;
  localparam logic [CharW-1:0] ChBs     = 8'h08;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChEsc    = 8'h1B;
  localparam logic [CharW-1:0] ChParenL = 8'h28;
  localparam logic [CharW-1:0] ChParenR = 8'h29;
  localparam logic [CharW-1:0] ChDigit0 = 8'h30;
  localparam logic [CharW-1:0] ChDigit9 = 8'h39;
  localparam logic [CharW-1:0] ChSemi   = 8'h3B;
  localparam logic [CharW-1:0] ChBrackL = 8'h5B;
  localparam logic [CharW-1:0] ChBrackR = 8'h5D;
  localparam logic [CharW-1:0] ChLowerM = 8'h6D;
  localparam logic [CharW-1:0] ChDel    = 8'h7F;
  localparam logic [CharW-1:0] ChCsi    = 8'h9B;
  localparam logic [CharW-1:0] ChOsc    = 8'h9D;
  localparam logic [CharW-1:0] ChShy    = 8'hAD;

  localparam logic [ParamW-1:0] SgrNormal   = 16'd0;
  localparam logic [ParamW-1:0] SgrBold     = 16'd1;
  localparam logic [ParamW-1:0] SgrBlack    = 16'd30;
  localparam logic [ParamW-1:0] SgrRed      = 16'd31;
  localparam logic [ParamW-1:0] SgrCyan     = 16'd36;
  localparam logic [ParamW-1:0] SgrWhite    = 16'd37;
  localparam logic [ParamW-1:0] SgrDefault  = 16'd39;
  localparam logic [ParamW-1:0] SgrColBase  = 16'd29;
  localparam logic [ParamW+3:0] ParamMax    = 20'd65535;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_INSERT    = 3'd1,
    ACT_NEWLINE   = 3'd2,
    ACT_DELETE    = 3'd3,
    ACT_BRACKETED = 3'd4,
    ACT_STYLE     = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    WGT_KEEP   = 2'd0,
    WGT_NORMAL = 2'd1,
    WGT_BOLD   = 2'd2
  } weight_e;

  typedef enum logic [2:0] {
    COL_KEEP    = 3'd0,
    COL_BLACK   = 3'd1,
    COL_RED     = 3'd2,
    COL_GREEN   = 3'd3,
    COL_YELLOW  = 3'd4,
    COL_BLUE    = 3'd5,
    COL_MAGENTA = 3'd6,
    COL_CYAN    = 3'd7
  } color_e;

  typedef struct packed {
    logic              in_escape;
    logic              in_csi;
    logic              in_osc;
    logic              sep_seen;
    logic              param_present;
    logic [ParamW-1:0] param;
  } seq_state_t;

  typedef struct packed {
    action_e          action;
    logic [CharW-1:0] char_out;
    weight_e          weight;
    color_e           color;
  } result_t;

  function automatic logic is_printable(input logic [CharW-1:0] c);
    is_printable = (c inside {[8'h20:8'h7E]}) || ((c inside {[8'hA0:8'hFF]}) && (c != ChShy));
  endfunction

endpackage

// ===== rtl/core/ansi_escape_stream_parser.sv =====
// Escape-sequence stream parser: top level with input, state and result registers.
// A request is held in the input register, then decoded and held in the result register.
// Throughput: one request per cycle while results are not stalled; aesp_step is combinational.
// Requests are stalled only while the input register holds a request and the result register
// holds a result that the receiver stalls.
// Reset clears all valid flags and the sequence state, and sets parse_ansi to 1.
// Depends on aesp_pkg, aesp_cfg and aesp_step.
module ansi_escape_stream_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aesp_pkg::PaddrW-1:0] paddr,
  input  logic [aesp_pkg::PdataW-1:0] pwdata,
  output logic [aesp_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  char_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  action_o,
  output logic [7:0]                  char_out_o,
  output logic [1:0]                  weight_change_o,
  output logic [2:0]                  color_change_o
);
  import aesp_pkg::*;

  logic             parse_ansi;
  logic             in_vld_q, in_vld_d;
  logic [CharW-1:0] char_q, char_d;
  seq_state_t       state_q, state_d, state_nxt;
  logic             out_vld_q, out_vld_d;
  result_t          res_q, res_d, res_nxt;
  logic             advance;
  logic             in_take;

  aesp_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .parse_ansi_o (parse_ansi)
  );

  aesp_step u_step (
    .char_i       (char_q),
    .parse_ansi_i (parse_ansi),
    .state_i      (state_q),
    .state_o      (state_nxt),
    .result_o     (res_nxt)
  );

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d  = in_vld_q;
    char_d    = char_q;
    state_d   = state_q;
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (advance) begin
      in_vld_d = 1'b0;
      state_d  = state_nxt;
      res_d    = res_nxt;
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (in_take) begin
      in_vld_d = 1'b1;
      char_d   = char_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    res_q  <= res_d;
  end

  assign out_valid_o     = out_vld_q;
  assign action_o        = res_q.action;
  assign char_out_o      = res_q.char_out;
  assign weight_change_o = res_q.weight;
  assign color_change_o  = res_q.color;

endmodule

// ===== rtl/core/aesp_cfg.sv =====
// Configuration register file for the escape-sequence stream parser.
// APB-style write and read of the parse_ansi register; depends on aesp_pkg.
module aesp_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aesp_pkg::PaddrW-1:0] paddr,
  input  logic [aesp_pkg::PdataW-1:0] pwdata,
  output logic [aesp_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  output logic                        parse_ansi_o
);
  import aesp_pkg::*;

  logic parse_ansi_q, parse_ansi_d;
  logic hit;
  logic wr_en;

  assign hit    = (paddr[PaddrW-1:2] == RegParseAnsi);
  assign wr_en  = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  always_comb begin
    parse_ansi_d = parse_ansi_q;
    if (wr_en) begin
      parse_ansi_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_ansi_q <= 1'b1;
    end else begin
      parse_ansi_q <= parse_ansi_d;
    end
  end

  assign prdata       = hit ? {{(PdataW-1){1'b0}}, parse_ansi_q} : '0;
  assign parse_ansi_o = parse_ansi_q;

endmodule

// ===== rtl/core/aesp_step.sv =====
// Per-character decode for the escape-sequence stream parser.
// Maps one character and the sequence state to the next state and one result.
// Depends on aesp_pkg.
module aesp_step (
  input  logic [aesp_pkg::CharW-1:0] char_i,
  input  logic                       parse_ansi_i,
  input  aesp_pkg::seq_state_t       state_i,
  output aesp_pkg::seq_state_t       state_o,
  output aesp_pkg::result_t          result_o
);
  import aesp_pkg::*;

  logic              ended;
  logic              is_digit;
  logic [ParamW+3:0] param_val;
  logic [ParamW+3:0] digit_val;

  assign is_digit  = (char_i inside {[ChDigit0:ChDigit9]});
  assign digit_val = (ParamW+4)'(char_i - ChDigit0);

  always_comb begin
    if (state_i.param_present) begin
      param_val = {state_i.param, 3'b000} + {2'b00, state_i.param, 1'b0} + digit_val;
    end else begin
      param_val = digit_val;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{action: ACT_NONE, char_out: '0, weight: WGT_KEEP, color: COL_KEEP};
    ended    = 1'b0;

    if (state_i.in_escape) begin
      if (state_i.in_csi || state_i.in_osc) begin
        if (is_digit) begin
          if (state_i.sep_seen) begin
            state_o.param         = (param_val > ParamMax) ? '1 : param_val[ParamW-1:0];
            state_o.param_present = 1'b1;
          end
        end else if (char_i == ChSemi) begin
          state_o.sep_seen = 1'b1;
        end else if (state_i.in_osc) begin
          ended = (char_i == ChBel);
        end else begin
          ended = (char_i != ChNul);
        end
      end else if (char_i == ChBrackL) begin
        state_o.in_csi = 1'b1;
      end else if (char_i == ChBrackR) begin
        state_o.in_osc = 1'b1;
      end else if ((char_i == ChParenL) || (char_i == ChParenR)) begin
        state_o = state_i;
      end else begin
        ended = (char_i != ChNul);
      end

      if (ended) begin
        state_o = '0;
        if (char_i == ChLowerM) begin
          result_o.action = ACT_STYLE;
          if (!state_i.param_present) begin
            result_o.color = COL_BLACK;
          end else if (state_i.param == SgrNormal) begin
            result_o.weight = WGT_NORMAL;
            result_o.color  = COL_BLACK;
          end else if (state_i.param == SgrBold) begin
            result_o.weight = WGT_BOLD;
          end else if (state_i.param inside {[SgrRed:SgrCyan]}) begin
            result_o.color = color_e'(3'(state_i.param - SgrColBase));
          end else if (state_i.param inside {SgrBlack, SgrWhite, SgrDefault}) begin
            result_o.color = COL_BLACK;
          end
        end
      end
    end else if (char_i == ChCr) begin
      result_o.action   = ACT_NEWLINE;
      result_o.char_out = ChLf;
    end else if (is_printable(char_i) || (char_i == ChLf)) begin
      result_o.action   = ACT_INSERT;
      result_o.char_out = char_i;
    end else if (parse_ansi_i) begin
      case (char_i)
        ChDel, ChBs: begin
          result_o.action = ACT_DELETE;
        end
        ChEsc: begin
          state_o.in_escape = 1'b1;
        end
        ChCsi: begin
          state_o.in_escape = 1'b1;
          state_o.in_csi    = 1'b1;
        end
        ChOsc: begin
          state_o.in_escape = 1'b1;
          state_o.in_osc    = 1'b1;
        end
        default: begin
          result_o.action = ACT_NONE;
        end
      endcase
    end else if (char_i != ChNul) begin
      result_o.action   = ACT_BRACKETED;
      result_o.char_out = char_i;
    end
  end

endmodule

// ===== rtl/core/aesp_checker.sv =====
// Port-level checks for the escape-sequence stream parser, bound to the top level.
// Depends on aesp_pkg and ansi_escape_stream_parser.
module aesp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [7:0] char_out_o,
  input logic [1:0] weight_change_o,
  input logic [2:0] color_change_o
);
  import aesp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled with result side free");

  a_style_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o != ACT_STYLE) |-> (weight_change_o == WGT_KEEP) &&
      (color_change_o == COL_KEEP))
    else $error("style change outside a style result");

  a_newline_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_NEWLINE) |-> (char_out_o == ChLf))
    else $error("newline result without line feed");

endmodule

bind ansi_escape_stream_parser aesp_checker u_aesp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .action_o        (action_o),
  .char_out_o      (char_out_o),
  .weight_change_o (weight_change_o),
  .color_change_o  (color_change_o)
);
